@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CRA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CRA_ASSERT(lbl, clk, rst_n, prop)
`define CRA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/cra_pkg.sv @@
// ----------------------------------------------------------------------------
// cra_pkg
// shared types and constants of the color ramp pipeline
// ----------------------------------------------------------------------------
package cra_pkg;

  localparam int AGE_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int FRAC_W       = 8;
  localparam int NUM_CHAN     = 4;
  localparam int STOP_COUNT_W = 3;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 3;

  localparam int CH_RED   = 3;
  localparam int CH_GREEN = 2;
  localparam int CH_BLUE  = 1;
  localparam int CH_ALPHA = 0;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgba_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STOP_COUNT   = 3'd0,
    REG_COLOR_STOP_0 = 3'd1,
    REG_COLOR_STOP_1 = 3'd2,
    REG_COLOR_STOP_2 = 3'd3,
    REG_COLOR_STOP_3 = 3'd4,
    REG_COLOR_STOP_4 = 3'd5,
    REG_COLOR_STOP_5 = 3'd6,
    REG_COLOR_STOP_6 = 3'd7
  } reg_idx_e;

endpackage

@@ hdl/cra_div.sv @@
// ----------------------------------------------------------------------------
// cra_div
// pipelined restoring divider, one quotient bit per stage, per-stage valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cra_div #(
  parameter int QUOT_W = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cra_pkg::AGE_W+QUOT_W-1:0]    num_i,
  input  logic [cra_pkg::AGE_W-1:0]           den_i,
  input  logic                                sat_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [QUOT_W-1:0]                   quo_o,
  output logic                                sat_o
);
  import cra_pkg::*;

  localparam int NUM_W = AGE_W + QUOT_W;

  logic [QUOT_W:0]   vld_q;
  logic [QUOT_W+1:0] rdy;
  logic [AGE_W-1:0]  rem_q [QUOT_W+1];
  logic [AGE_W-1:0]  den_q [QUOT_W+1];
  logic [QUOT_W-1:0] low_q [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q [QUOT_W+1];
  logic              sat_q [QUOT_W+1];

  assign rdy[QUOT_W+1] = out_ready_i;

  genvar k;
  generate
    for (k = 0; k <= QUOT_W; k++) begin : g_rdy
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end
  endgenerate

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0] <= num_i[NUM_W-1:QUOT_W];
      low_q[0] <= num_i[QUOT_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= sat_i;
    end
  end

  // one subtract and compare per stage
  generate
    for (k = 1; k <= QUOT_W; k++) begin : g_step
      logic [AGE_W:0]   trial;
      logic [AGE_W:0]   diff;
      logic             ge;
      logic [AGE_W-1:0] rem_d;

      assign trial = {rem_q[k-1], low_q[k-1][QUOT_W-1]};
      assign diff  = trial - {1'b0, den_q[k-1]};
      assign ge    = trial >= {1'b0, den_q[k-1]};
      assign rem_d = ge ? diff[AGE_W-1:0] : trial[AGE_W-1:0];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_q[k-1]) begin
          rem_q[k] <= rem_d;
          low_q[k] <= {low_q[k-1][QUOT_W-2:0], 1'b0};
          den_q[k] <= den_q[k-1];
          quo_q[k] <= {quo_q[k-1][QUOT_W-2:0], ge};
          sat_q[k] <= sat_q[k-1];
        end
      end
    end
  endgenerate

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[QUOT_W];
  assign quo_o       = quo_q[QUOT_W];
  assign sat_o       = sat_q[QUOT_W];

  `CRA_ASSERT(a_rem_below_den, clk_i, rst_ni, out_valid_o && !sat_o |-> rem_q[QUOT_W] < den_q[QUOT_W])
  `CRA_ASSERT_NEVER(a_blocked_empty, clk_i, rst_ni, !in_ready_o && !vld_q[0])
  `CRA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(quo_o))

endmodule

@@ hdl/color_ramp_by_age.sv @@
// an accepted transaction passes the divider stages, then stages a to d,
//   before its color shows; QUOT_W = 8 + clog2(MAX_STOPS)
// throughput: one transaction per cycle unless out_ready_i stalls the pipeline
// reset: stop_count returns to 1, all color stops to 0, pipeline empties
// ----------------------------------------------------------------------------
// color_ramp_by_age
// particle RGBA color from a piecewise linear ramp of evenly spaced stops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module color_ramp_by_age #(
  parameter int MAX_STOPS = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cra_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [cra_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [cra_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cra_pkg::AGE_W-1:0]       particle_age_i,
  input  logic [cra_pkg::AGE_W-1:0]       death_age_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cra_pkg::CHAN_W-1:0]      red_o,
  output logic [cra_pkg::CHAN_W-1:0]      green_o,
  output logic [cra_pkg::CHAN_W-1:0]      blue_o,
  output logic [cra_pkg::CHAN_W-1:0]      alpha_o
);
  import cra_pkg::*;

  localparam int IDX_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int QUOT_W = FRAC_W + IDX_W;
  localparam int PROD_W = AGE_W + IDX_W;
  localparam int DIFF_W = CHAN_W + 1;
  localparam int MUL_W  = 2 * DIFF_W;

  // configuration registers
  logic [STOP_COUNT_W-1:0] stop_count_q;
  logic [APB_DATA_W-1:0]   stop_q [MAX_STOPS];
  logic                    wr_en;
  reg_idx_e                reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= STOP_COUNT_W'(1);
    end else if (wr_en && reg_sel == REG_STOP_COUNT) begin
      stop_count_q <= pwdata[STOP_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (wr_en && reg_sel == reg_idx_e'(REG_COLOR_STOP_0 + REG_IDX_W'(k))) begin
          stop_q[k] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_STOP_COUNT) begin
      prdata = APB_DATA_W'(stop_count_q);
    end
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (reg_sel == reg_idx_e'(REG_COLOR_STOP_0 + REG_IDX_W'(k))) begin
        prdata = stop_q[k];
      end
    end
  end

  // last stop index in use
  logic [IDX_W-1:0] nm1;

  always_comb begin
    if (stop_count_q == '0) begin
      nm1 = '0;
    end else if (stop_count_q > STOP_COUNT_W'(MAX_STOPS)) begin
      nm1 = IDX_W'(MAX_STOPS - 1);
    end else begin
      nm1 = IDX_W'(stop_count_q - STOP_COUNT_W'(1));
    end
  end

  // position = age * (n-1) * 256 / death
  logic [PROD_W-1:0] prod_in;
  logic              sat_in;
  logic              div_valid;
  logic              div_sat;
  logic [QUOT_W-1:0] div_quo;
  logic              ready_a;

  assign prod_in = PROD_W'(particle_age_i) * PROD_W'(nm1);
  assign sat_in  = particle_age_i >= death_age_i;

  cra_div #(
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .num_i       ({prod_in, FRAC_W'(0)}),
    .den_i       (death_age_i),
    .sat_i       (sat_in),
    .out_valid_o (div_valid),
    .out_ready_i (ready_a),
    .quo_o       (div_quo),
    .sat_o       (div_sat)
  );

  // stage a: stop selection
  logic              va_q, vb_q, vc_q, vd_q;
  logic              ready_b, ready_c, ready_d;
  logic [IDX_W-1:0]  idx_a_d, nxt_a_d, idx_a_q, nxt_a_q, idx_raw;
  logic [FRAC_W-1:0] frac_a_d, frac_a_q;
  logic              sat_a_q;

  assign ready_d = !vd_q || out_ready_i;
  assign ready_c = !vc_q || ready_d;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;

  assign idx_raw = div_quo[QUOT_W-1:FRAC_W];

  always_comb begin
    if (div_sat) begin
      idx_a_d  = nm1;
      frac_a_d = '0;
    end else begin
      idx_a_d  = (idx_raw > nm1) ? nm1 : idx_raw;
      frac_a_d = div_quo[FRAC_W-1:0];
    end
    nxt_a_d = (idx_a_d < nm1) ? idx_a_d + IDX_W'(1) : nm1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= div_valid;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (ready_c) begin
        vc_q <= vb_q;
      end
      if (ready_d) begin
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && div_valid) begin
      idx_a_q  <= idx_a_d;
      nxt_a_q  <= nxt_a_d;
      frac_a_q <= frac_a_d;
      sat_a_q  <= div_sat;
    end
  end

  // stage b: stop fetch and channel difference
  rgba_t                    lo_stop, hi_stop;
  logic [CHAN_W-1:0]        c0_b_q  [NUM_CHAN];
  logic signed [DIFF_W-1:0] diff_b_q [NUM_CHAN];
  logic [FRAC_W-1:0]        frac_b_q;

  assign lo_stop = rgba_t'(stop_q[idx_a_q]);
  assign hi_stop = rgba_t'(stop_q[nxt_a_q]);

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        c0_b_q[ch]   <= lo_stop[ch];
        diff_b_q[ch] <= $signed({1'b0, hi_stop[ch]}) - $signed({1'b0, lo_stop[ch]});
      end
      frac_b_q <= frac_a_q;
    end
  end

  // stage c: weight by fraction
  logic [CHAN_W-1:0]       c0_c_q   [NUM_CHAN];
  logic signed [MUL_W-1:0] prod_c_q [NUM_CHAN];

  always_ff @(posedge clk_i) begin
    if (ready_c && vb_q) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        c0_c_q[ch]   <= c0_b_q[ch];
        prod_c_q[ch] <= diff_b_q[ch] * $signed({1'b0, frac_b_q});
      end
    end
  end

  // stage d: flooring shift and add, output register
  rgba_t out_q;

  always_ff @(posedge clk_i) begin
    if (ready_d && vc_q) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        out_q[ch] <= c0_c_q[ch] + prod_c_q[ch][FRAC_W+CHAN_W-1:FRAC_W];
      end
    end
  end

  assign out_valid_o = vd_q;
  assign red_o       = out_q[CH_RED];
  assign green_o     = out_q[CH_GREEN];
  assign blue_o      = out_q[CH_BLUE];
  assign alpha_o     = out_q[CH_ALPHA];

  `CRA_ASSERT(a_sat_last_stop, clk_i, rst_ni, va_q && sat_a_q |-> idx_a_q == nxt_a_q && frac_a_q == '0)
  `CRA_ASSERT(a_nxt_not_below, clk_i, rst_ni, va_q |-> idx_a_q <= nxt_a_q)
  `CRA_ASSERT(a_b_stall_hold, clk_i, rst_ni, vb_q && !ready_c |=> vb_q && $stable(frac_b_q))

endmodule
